// File: design/assert_macros.svh
// Assertion macros for the solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define QRS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define QRS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/qrs_pkg.sv
// Shared widths, types and helpers of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int COEF_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TOL_W      = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);
   localparam int CNT_W      = 2;
   localparam int PROD_W     = 2 * COEF_W;
   localparam int D_W        = PROD_W + 2;
   localparam int ROOT_W     = D_W / 2;
   localparam int SQ_REM_W   = ROOT_W + 3;
   localparam int NUM_W      = ROOT_W + 2;
   localparam int NMAG_W     = ROOT_W + 1;
   localparam int DS_W       = COEF_W + 2;
   localparam int DEN_W      = COEF_W + 1;
   localparam int Q_W        = COEF_W + 1;
   localparam int HI_SHIFT   = Q_W - FRAC_BITS;
   localparam int HI_W       = NMAG_W - HI_SHIFT;
   localparam int REQ_W      = ((3 * COEF_W + 7) / 8) * 8;
   localparam int RSP_BITS   = CNT_W + 4 * COEF_W + 1;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [CNT_W-1:0] {
      CNT_NONE = 2'd0,
      CNT_ONE  = 2'd1,
      CNT_TWO  = 2'd2,
      CNT_INF  = 2'd3
   } cnt_type;

   typedef struct packed {
      logic              lin;
      cnt_type           cnt;
      logic              d_neg;
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] c;
   } fr_side_type;

   typedef struct packed {
      logic    lin;
      cnt_type cnt;
      logic    d_neg;
      logic    den_zero;
   } dv_side_type;

   typedef struct packed {
      logic              sat;
      logic [COEF_W-1:0] val;
   } clip_type;

   // Apply sign to a quotient magnitude and clip to the coefficient range.
   function automatic clip_type clip_q(input logic [Q_W-1:0] q, input logic ovf,
                                       input logic neg);
      clip_type r;
      logic [COEF_W-1:0] low;
      low = q[COEF_W-1:0];
      if (neg) begin
         r.sat = ovf || q[Q_W-1] || (q[COEF_W-1] && (|q[COEF_W-2:0]));
         r.val = r.sat ? {1'b1, {(COEF_W-1){1'b0}}} : (~low + 1'b1);
      end else begin
         r.sat = ovf || (|q[Q_W-1:COEF_W-1]);
         r.val = r.sat ? {1'b0, {(COEF_W-1){1'b1}}} : low;
      end
      return r;
   endfunction
endpackage

// File: design/qrs_front.sv
// Front end: magnitudes, zero tests, products and the discriminant.
`timescale 1ns / 1ps
module qrs_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_vld,
   input  logic [qrs_pkg::COEF_W-1:0]      in_a,
   input  logic [qrs_pkg::COEF_W-1:0]      in_b,
   input  logic [qrs_pkg::COEF_W-1:0]      in_c,
   input  logic [qrs_pkg::TOL_W-1:0]       tol,
   output logic                            out_vld,
   output qrs_pkg::fr_side_type            out_side,
   output logic [qrs_pkg::D_W-1:0]         out_rad
);
   localparam int CW = qrs_pkg::COEF_W;

   // stage 0: captured coefficients
   logic vld0_ff;
   logic [CW-1:0] a0_ff, b0_ff, c0_ff;

   // stage 1: magnitudes and zero tests
   logic vld1_ff;
   logic [CW-1:0] ma_in, mb_in, mc_in, ma1_ff, mb1_ff, mc1_ff;
   logic [CW-1:0] a1_ff, b1_ff, c1_ff, tol_ext;
   logic lin_in, lin1_ff, mixed_in, mixed1_ff, b_near, c_near;
   qrs_pkg::cnt_type lcnt_in, lcnt1_ff;

   // stage 2: products
   logic vld2_ff, lin2_ff, mixed2_ff;
   logic [qrs_pkg::PROD_W-1:0] p_in, q_in, p2_ff, q2_ff;
   logic [CW-1:0] a2_ff, b2_ff, c2_ff;
   qrs_pkg::cnt_type lcnt2_ff;

   // stage 3: discriminant magnitude and sign
   logic vld3_ff, lin3_ff, dneg_in, dneg3_ff;
   logic [qrs_pkg::D_W-1:0] p66, q4, d_sum, d_pq, d_qp, d_in, d3_ff, tol_d;
   logic [CW-1:0] a3_ff, b3_ff, c3_ff;
   qrs_pkg::cnt_type lcnt3_ff, cnt_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= in_vld;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_comb begin
      tol_ext  = {{(CW-qrs_pkg::TOL_W){1'b0}}, tol};
      ma_in    = a0_ff[CW-1] ? (~a0_ff + 1'b1) : a0_ff;
      mb_in    = b0_ff[CW-1] ? (~b0_ff + 1'b1) : b0_ff;
      mc_in    = c0_ff[CW-1] ? (~c0_ff + 1'b1) : c0_ff;
      lin_in   = (a0_ff == '0) || (ma_in < tol_ext);
      b_near   = mb_in < tol_ext;
      c_near   = mc_in < tol_ext;
      mixed_in = (a0_ff[CW-1] != c0_ff[CW-1]) && (c0_ff != '0);
      if (!b_near)
         lcnt_in = qrs_pkg::CNT_ONE;
      else if (c_near)
         lcnt_in = qrs_pkg::CNT_INF;
      else
         lcnt_in = qrs_pkg::CNT_NONE;
   end

   assign p_in = mb1_ff * mb1_ff;
   assign q_in = ma1_ff * mc1_ff;

   always_comb begin
      p66   = {2'b00, p2_ff};
      q4    = {q2_ff, 2'b00};
      d_sum = p66 + q4;
      d_pq  = p66 - q4;
      d_qp  = q4 - p66;
      if (mixed2_ff) begin
         d_in    = d_sum;
         dneg_in = 1'b0;
      end else if (q4 <= p66) begin
         d_in    = d_pq;
         dneg_in = 1'b0;
      end else begin
         d_in    = d_qp;
         dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff     <= in_a;
         b0_ff     <= in_b;
         c0_ff     <= in_c;
         ma1_ff    <= ma_in;
         mb1_ff    <= mb_in;
         mc1_ff    <= mc_in;
         a1_ff     <= a0_ff;
         b1_ff     <= b0_ff;
         c1_ff     <= c0_ff;
         lin1_ff   <= lin_in;
         mixed1_ff <= mixed_in;
         lcnt1_ff  <= lcnt_in;
         p2_ff     <= p_in;
         q2_ff     <= q_in;
         a2_ff     <= a1_ff;
         b2_ff     <= b1_ff;
         c2_ff     <= c1_ff;
         lin2_ff   <= lin1_ff;
         mixed2_ff <= mixed1_ff;
         lcnt2_ff  <= lcnt1_ff;
         d3_ff     <= d_in;
         dneg3_ff  <= dneg_in;
         a3_ff     <= a2_ff;
         b3_ff     <= b2_ff;
         c3_ff     <= c2_ff;
         lin3_ff   <= lin2_ff;
         lcnt3_ff  <= lcnt2_ff;
      end
   end

   // D counts as zero below tolerance scaled to D's format
   always_comb begin
      tol_d = {{(qrs_pkg::D_W-qrs_pkg::TOL_W-qrs_pkg::FRAC_BITS){1'b0}}, tol,
               {qrs_pkg::FRAC_BITS{1'b0}}};
      if (lin3_ff)
         cnt_out = lcnt3_ff;
      else if (d3_ff < tol_d)
         cnt_out = qrs_pkg::CNT_ONE;
      else
         cnt_out = qrs_pkg::CNT_TWO;
   end

   assign out_vld        = vld3_ff;
   assign out_rad        = d3_ff;
   assign out_side.lin   = lin3_ff;
   assign out_side.cnt   = cnt_out;
   assign out_side.d_neg = dneg3_ff && !lin3_ff;
   assign out_side.a     = a3_ff;
   assign out_side.b     = b3_ff;
   assign out_side.c     = c3_ff;
endmodule

// File: design/qrs_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`timescale 1ns / 1ps
module qrs_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  qrs_pkg::fr_side_type        in_side,
   input  logic [qrs_pkg::D_W-1:0]     in_rad,
   output logic                        out_vld,
   output qrs_pkg::fr_side_type        out_side,
   output logic [qrs_pkg::ROOT_W-1:0]  out_root
);
   localparam int N  = qrs_pkg::ROOT_W;
   localparam int W  = qrs_pkg::SQ_REM_W;
   localparam int DW = qrs_pkg::D_W;

   logic                 vld_cur  [0:N-1];
   qrs_pkg::fr_side_type side_cur [0:N-1];
   logic [N-1:0]         root_cur [0:N-1];
   logic [W-1:0]         rem_cur  [0:N-1];
   logic [DW-1:0]        rad_cur  [0:N-1];

   logic                 vld_ff   [1:N];
   qrs_pkg::fr_side_type side_ff  [1:N];
   logic [N-1:0]         root_ff  [1:N];
   logic [W-1:0]         rem_ff   [1:N-1];
   logic [DW-1:0]        rad_ff   [1:N-1];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [W-1:0] rs, tv, diff;
      logic ge;
      logic [N-1:0] root_in;

      if (k == 0) begin : g_head
         assign vld_cur[k]  = in_vld;
         assign side_cur[k] = in_side;
         assign root_cur[k] = '0;
         assign rem_cur[k]  = '0;
         assign rad_cur[k]  = in_rad;
      end else begin : g_body
         assign vld_cur[k]  = vld_ff[k];
         assign side_cur[k] = side_ff[k];
         assign root_cur[k] = root_ff[k];
         assign rem_cur[k]  = rem_ff[k];
         assign rad_cur[k]  = rad_ff[k];
      end

      always_comb begin
         rs      = {rem_cur[k][W-3:0], rad_cur[k][DW-1:DW-2]};
         tv      = {{(W-N-2){1'b0}}, root_cur[k], 2'b01};
         diff    = rs - tv;
         ge      = rs >= tv;
         root_in = {root_cur[k][N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset)
            vld_ff[k+1] <= 1'b0;
         else if (en)
            vld_ff[k+1] <= vld_cur[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_cur[k];
            root_ff[k+1] <= root_in;
         end
      end

      if (k < N-1) begin : g_carry
         logic [W-1:0]  rem_in;
         logic [DW-1:0] rad_in;
         assign rem_in = ge ? diff : rs;
         assign rad_in = {rad_cur[k][DW-3:0], 2'b00};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= rem_in;
               rad_ff[k+1] <= rad_in;
            end
         end
      end
   end

   assign out_vld  = vld_ff[N];
   assign out_side = side_ff[N];
   assign out_root = root_ff[N];
endmodule

// File: design/qrs_div.sv
// Numerator setup and two-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module qrs_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_vld,
   input  qrs_pkg::fr_side_type                in_side,
   input  logic [qrs_pkg::ROOT_W-1:0]          in_root,
   output logic                                out_vld,
   output qrs_pkg::dv_side_type                out_side,
   output logic [1:0][qrs_pkg::Q_W-1:0]        out_q,
   output logic [1:0]                          out_ovf,
   output logic [1:0]                          out_neg
);
   localparam int CW  = qrs_pkg::COEF_W;
   localparam int NW  = qrs_pkg::NUM_W;
   localparam int MW  = qrs_pkg::NMAG_W;
   localparam int DSW = qrs_pkg::DS_W;
   localparam int DNW = qrs_pkg::DEN_W;
   localparam int QW  = qrs_pkg::Q_W;
   localparam int HS  = qrs_pkg::HI_SHIFT;
   localparam int HW  = qrs_pkg::HI_W;

   // entry: numerators and divisor as sign plus magnitude
   logic [NW-1:0] bx, cx, sx, nbx;
   logic [1:0][NW-1:0] num, nabs;
   logic [DSW-1:0] den, dabs;
   logic den_neg;
   logic [1:0] neg_in;
   qrs_pkg::dv_side_type eside_in;

   logic e_vld_ff;
   qrs_pkg::dv_side_type e_side_ff;
   logic [1:0][MW-1:0] e_nmag_ff;
   logic [1:0] e_neg_ff;
   logic [DNW-1:0] e_dmag_ff;

   // range check and remainder seed
   logic [1:0][DNW-1:0] orem_in;
   logic [1:0][QW-1:0] olow_in;
   logic [1:0] oovf_in;

   logic o_vld_ff;
   qrs_pkg::dv_side_type o_side_ff;
   logic [1:0][DNW-1:0] o_rem_ff;
   logic [1:0][QW-1:0] o_low_ff;
   logic [1:0] o_ovf_ff, o_neg_ff;
   logic [DNW-1:0] o_dmag_ff;

   always_comb begin
      bx  = {{(NW-CW){in_side.b[CW-1]}}, in_side.b};
      cx  = {{(NW-CW){in_side.c[CW-1]}}, in_side.c};
      sx  = {{(NW-qrs_pkg::ROOT_W){1'b0}}, in_root};
      nbx = ~bx + 1'b1;
      if (in_side.lin)
         den = {{2{in_side.b[CW-1]}}, in_side.b};
      else
         den = {in_side.a[CW-1], in_side.a, 1'b0};
      den_neg = den[DSW-1];
      dabs    = den_neg ? (~den + 1'b1) : den;
      if (in_side.lin) begin
         num[0] = ~cx + 1'b1;
         num[1] = '0;
      end else if (in_side.d_neg) begin
         num[0] = nbx;
         num[1] = sx;
      end else begin
         num[0] = nbx - sx;
         num[1] = nbx + sx;
      end
      for (int l = 0; l < 2; l++) begin
         nabs[l]   = num[l][NW-1] ? (~num[l] + 1'b1) : num[l];
         neg_in[l] = num[l][NW-1] ^ den_neg;
      end
      eside_in.lin      = in_side.lin;
      eside_in.cnt      = in_side.cnt;
      eside_in.d_neg    = in_side.d_neg;
      eside_in.den_zero = (dabs == '0);
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         orem_in[l] = {{(DNW-HW){1'b0}}, e_nmag_ff[l][MW-1:HS]};
         oovf_in[l] = orem_in[l] >= e_dmag_ff;
         olow_in[l] = {e_nmag_ff[l][HS-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= in_vld;
         o_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_side_ff <= eside_in;
         e_nmag_ff <= {nabs[1][MW-1:0], nabs[0][MW-1:0]};
         e_neg_ff  <= neg_in;
         e_dmag_ff <= dabs[DNW-1:0];
         o_side_ff <= e_side_ff;
         o_rem_ff  <= orem_in;
         o_low_ff  <= olow_in;
         o_ovf_ff  <= oovf_in;
         o_neg_ff  <= e_neg_ff;
         o_dmag_ff <= e_dmag_ff;
      end
   end

   // quotient steps
   logic                    vld_cur  [0:QW-1];
   qrs_pkg::dv_side_type    side_cur [0:QW-1];
   logic [DNW-1:0]          dmag_cur [0:QW-1];
   logic [1:0][DNW-1:0]     rem_cur  [0:QW-1];
   logic [1:0][QW-1:0]      low_cur  [0:QW-1];
   logic [1:0][QW-1:0]      q_cur    [0:QW-1];
   logic [1:0]              ovf_cur  [0:QW-1];
   logic [1:0]              neg_cur  [0:QW-1];

   logic                    vld_ff   [1:QW];
   qrs_pkg::dv_side_type    side_ff  [1:QW];
   logic [1:0][QW-1:0]      q_ff     [1:QW];
   logic [1:0]              ovf_ff   [1:QW];
   logic [1:0]              neg_ff   [1:QW];
   logic [DNW-1:0]          dmag_ff  [1:QW-1];
   logic [1:0][DNW-1:0]     rem_ff   [1:QW-1];
   logic [1:0][QW-1:0]      low_ff   [1:QW-1];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [1:0][DNW:0] rs, diff;
      logic [1:0] ge;
      logic [1:0][QW-1:0] q_in;

      if (k == 0) begin : g_head
         assign vld_cur[k]  = o_vld_ff;
         assign side_cur[k] = o_side_ff;
         assign dmag_cur[k] = o_dmag_ff;
         assign rem_cur[k]  = o_rem_ff;
         assign low_cur[k]  = o_low_ff;
         assign q_cur[k]    = '0;
         assign ovf_cur[k]  = o_ovf_ff;
         assign neg_cur[k]  = o_neg_ff;
      end else begin : g_body
         assign vld_cur[k]  = vld_ff[k];
         assign side_cur[k] = side_ff[k];
         assign dmag_cur[k] = dmag_ff[k];
         assign rem_cur[k]  = rem_ff[k];
         assign low_cur[k]  = low_ff[k];
         assign q_cur[k]    = q_ff[k];
         assign ovf_cur[k]  = ovf_ff[k];
         assign neg_cur[k]  = neg_ff[k];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            rs[l]   = {rem_cur[k][l], low_cur[k][l][QW-1-k]};
            diff[l] = rs[l] - {1'b0, dmag_cur[k]};
            ge[l]   = rs[l] >= {1'b0, dmag_cur[k]};
            q_in[l] = {q_cur[k][l][QW-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset)
            vld_ff[k+1] <= 1'b0;
         else if (en)
            vld_ff[k+1] <= vld_cur[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_cur[k];
            q_ff[k+1]    <= q_in;
            ovf_ff[k+1]  <= ovf_cur[k];
            neg_ff[k+1]  <= neg_cur[k];
         end
      end

      if (k < QW-1) begin : g_carry
         logic [1:0][DNW-1:0] rem_in;
         always_comb begin
            for (int l = 0; l < 2; l++)
               rem_in[l] = ge[l] ? diff[l][DNW-1:0] : rs[l][DNW-1:0];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1]  <= rem_in;
               low_ff[k+1]  <= low_cur[k];
               dmag_ff[k+1] <= dmag_cur[k];
            end
         end
      end
   end

   assign out_vld  = vld_ff[QW];
   assign out_side = side_ff[QW];
   assign out_q    = q_ff[QW];
   assign out_ovf  = ovf_ff[QW];
   assign out_neg  = neg_ff[QW];
endmodule

// File: design/quadratic_root_solver_core.sv
// Top level of the quadratic root solver: channels, pipeline and output buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
// req channel: one transfer carries a coefficient set (a, b, c).
// rsp channel: one transfer per request, in request order, with the root
//   count, two complex roots (Q16.16, clipped) and a saturation flag.
// csr port: csr_wr_en writes the zero tolerance (LSBs); write only while idle.
// Pipeline: the transfer edge loads the first of 4 front stages
//   (products, discriminant), then 33 square root stages (one root bit each),
//   2 divider setup stages, 33 divider stages (one quotient bit each) and
//   the output register.
// Throughput: one request per cycle unless the pipeline is frozen (see
//   Stall), set by the one-bit-per-stage sqrt and divider pipelines; every
//   stage registers its own valid bit.
// Stall: a result the receiver does not take waits in the output register;
//   the next one lands in a one-entry skid buffer, and only then does the
//   whole pipeline freeze and req_tready drop. req_tready is a register.
// Reset (synchronous, active high) empties the pipeline and both output
//   slots and sets the tolerance to 1.
module quadratic_root_solver_core (
   input  logic                         clock,
   input  logic                         reset,
   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
   input  logic [qrs_pkg::REQ_W-1:0]    req_tdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // root_count [1:0], first_real [33:2], first_imag [65:34],
   // second_real [97:66], second_imag [129:98], saturated [130], zero fill
   output logic [qrs_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_wr_en,
   input  logic [qrs_pkg::TOL_W-1:0]    csr_wr_data
);
   localparam int CW = qrs_pkg::COEF_W;

   logic [qrs_pkg::TOL_W-1:0] tol_ff;
   logic pipe_en;

   logic fr_vld, sq_vld, div_vld;
   qrs_pkg::fr_side_type fr_side, sq_side;
   logic [qrs_pkg::D_W-1:0] fr_rad;
   logic [qrs_pkg::ROOT_W-1:0] sq_root;
   qrs_pkg::dv_side_type dv_side;
   logic [1:0][qrs_pkg::Q_W-1:0] dv_q;
   logic [1:0] dv_ovf, dv_neg;

   qrs_pkg::clip_type r0, i_pos, i_neg;
   logic [CW-1:0] fr, fi, sr, si;
   logic sat;
   logic [qrs_pkg::RSP_W-1:0] res_data;

   logic out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in, take;
   logic [qrs_pkg::RSP_W-1:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset)
         tol_ff <= qrs_pkg::TOL_RESET;
      else if (csr_wr_en)
         tol_ff <= csr_wr_data;
   end

   // whole pipeline advances while the skid slot is free
   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;

   qrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (req_tvalid),
      .in_a     (req_tdata[CW-1:0]),
      .in_b     (req_tdata[2*CW-1:CW]),
      .in_c     (req_tdata[3*CW-1:2*CW]),
      .tol      (tol_ff),
      .out_vld  (fr_vld),
      .out_side (fr_side),
      .out_rad  (fr_rad)
   );

   qrs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (fr_vld),
      .in_side  (fr_side),
      .in_rad   (fr_rad),
      .out_vld  (sq_vld),
      .out_side (sq_side),
      .out_root (sq_root)
   );

   qrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (sq_vld),
      .in_side  (sq_side),
      .in_root  (sq_root),
      .out_vld  (div_vld),
      .out_side (dv_side),
      .out_q    (dv_q),
      .out_ovf  (dv_ovf),
      .out_neg  (dv_neg)
   );

   // sign, clip and route the quotients into the result fields
   always_comb begin
      r0    = qrs_pkg::clip_q(dv_q[0], dv_ovf[0], dv_neg[0]);
      i_pos = qrs_pkg::clip_q(dv_q[1], dv_ovf[1], dv_neg[1]);
      i_neg = qrs_pkg::clip_q(dv_q[1], dv_ovf[1], !dv_neg[1]);
      fr  = '0;
      fi  = '0;
      sr  = '0;
      si  = '0;
      sat = 1'b0;
      priority if (dv_side.den_zero) begin
         // linear case with b exactly zero: root reads as zero
         fr = '0;
      end else if (dv_side.lin) begin
         fr  = r0.val;
         sat = r0.sat;
      end else if (dv_side.d_neg) begin
         // conjugate pair: lane 1 carries sqrt(|D|)/(2a)
         fr  = r0.val;
         sr  = r0.val;
         fi  = i_neg.val;
         si  = i_pos.val;
         sat = r0.sat || i_neg.sat || i_pos.sat;
      end else begin
         fr  = r0.val;
         sr  = i_pos.val;
         sat = r0.sat || i_pos.sat;
      end
      res_data = {{(qrs_pkg::RSP_W-qrs_pkg::RSP_BITS){1'b0}}, sat, si, sr, fi, fr,
                  dv_side.cnt};
   end

   // output register plus one-entry skid buffer
   assign take = out_vld_ff && rsp_tready;

   always_comb begin
      out_vld_in   = out_vld_ff && !take;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         // pipeline frozen; drain the skid slot first
         if (take) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || take) begin
         out_vld_in  = div_vld;
         out_data_in = res_data;
      end else if (div_vld) begin
         out_vld_in   = 1'b1;
         skid_vld_in  = 1'b1;
         skid_data_in = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // skid slot is only ever filled behind a held result
   `QRS_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_vld_ff, out_vld_ff)
   // a frozen pipeline keeps its last stage
   `QRS_ASSERT_NEXT(a_freeze_holds, clock, reset, !pipe_en, $stable(div_vld))
   // imaginary parts only come as a conjugate pair with equal real parts
   `QRS_ASSERT_IMPL(a_pair_real, clock, reset, out_vld_ff && (rsp_tdata[129:98] != '0), rsp_tdata[97:66] == rsp_tdata[33:2])
   // an imaginary part only comes with a root count of one or two
   `QRS_ASSERT_IMPL(a_imag_count, clock, reset, out_vld_ff && (rsp_tdata[65:34] != '0), (rsp_tdata[1:0] == qrs_pkg::CNT_ONE) || (rsp_tdata[1:0] == qrs_pkg::CNT_TWO))
endmodule

// File: test/quadratic_root_solver_core_checker.sv
// Result checker for the quadratic root solver: predicts each response and compares it.
`timescale 1ns / 1ps
module quadratic_root_solver_core_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [qrs_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [qrs_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_wr_en,
   input  logic [qrs_pkg::TOL_W-1:0] csr_wr_data,
   output int                        fail_count,
   output int                        pending
);
   typedef struct packed {
      qrs_pkg::cnt_type           cnt;
      logic [qrs_pkg::COEF_W-1:0] r1;
      logic [qrs_pkg::COEF_W-1:0] i1;
      logic [qrs_pkg::COEF_W-1:0] r2;
      logic [qrs_pkg::COEF_W-1:0] i2;
      logic                       sat;
   } roots_type;

   roots_type                   roots_due[$];
   logic [qrs_pkg::TOL_W-1:0]   tolerance;

   function automatic logic is_small(input longint v, input logic [qrs_pkg::TOL_W-1:0] tol);
      longint m;
      m = (v < 0) ? -v : v;
      return m < longint'(tol);
   endfunction

   // Quotient (num << FRAC_BITS) / den, truncated, clipped to coefficient range.
   function automatic logic [qrs_pkg::COEF_W-1:0] div_clip(input logic signed [127:0] num,
                                                           input longint den,
                                                           inout logic sat);
      logic signed [127:0] q;
      if (den == 0) return '0;
      q = (num <<< qrs_pkg::FRAC_BITS) / 128'(signed'(den));
      if (q > 128'sh7fffffff) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (q < -128'sh80000000) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return q[qrs_pkg::COEF_W-1:0];
   endfunction

   function automatic roots_type solve_roots(input logic [qrs_pkg::REQ_W-1:0] d,
                                             input logic [qrs_pkg::TOL_W-1:0] tol);
      roots_type r;
      longint a, b, c;
      logic signed [127:0] disc, dmag;
      logic [127:0] s;
      a = longint'(signed'(d[31:0]));
      b = longint'(signed'(d[63:32]));
      c = longint'(signed'(d[95:64]));
      r = '0;
      if (a == 0 || is_small(a, tol)) begin
         if (is_small(b, tol))
            r.cnt = is_small(c, tol) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
         else r.cnt = qrs_pkg::CNT_ONE;
         r.r1 = div_clip(-128'(signed'(c)), b, r.sat);
      end else begin
         disc = 128'(signed'(b)) * b - 128'sd4 * a * c;
         dmag = (disc < 0) ? -disc : disc;
         s = 0;
         for (int k = 33; k >= 0; k--)
            if ((s | (128'd1 << k)) * (s | (128'd1 << k)) <= dmag) s = s | (128'd1 << k);
         // |D| below the scaled tolerance counts as one root, whatever its sign
         r.cnt = (dmag < (128'(tol) << qrs_pkg::FRAC_BITS)) ? qrs_pkg::CNT_ONE
                                                           : qrs_pkg::CNT_TWO;
         if (disc < 0) begin
            r.r1 = div_clip(-128'(signed'(b)), 2 * a, r.sat);
            r.r2 = r.r1;
            r.i1 = div_clip(-signed'(s), 2 * a, r.sat);
            r.i2 = div_clip(signed'(s), 2 * a, r.sat);
         end else begin
            r.r1 = div_clip(-128'(signed'(b)) - signed'(s), 2 * a, r.sat);
            r.r2 = div_clip(-128'(signed'(b)) + signed'(s), 2 * a, r.sat);
         end
      end
      return r;
   endfunction

   assign pending = roots_due.size();

   always @(posedge clock) begin
      roots_type exp_r, got;
      if (reset) begin
         tolerance  <= qrs_pkg::TOL_RESET;
         fail_count <= 0;
         roots_due.delete();
      end else begin
         if (csr_wr_en) tolerance <= csr_wr_data;
         if (req_tvalid && req_tready) roots_due.push_back(solve_roots(req_tdata, tolerance));
         if (rsp_tvalid && rsp_tready) begin
            got.cnt = qrs_pkg::cnt_type'(rsp_tdata[1:0]);
            got.r1  = rsp_tdata[33:2];
            got.i1  = rsp_tdata[65:34];
            got.r2  = rsp_tdata[97:66];
            got.i2  = rsp_tdata[129:98];
            got.sat = rsp_tdata[130];
            if (roots_due.size() == 0) begin
               $error("response transfer with none expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = roots_due.pop_front();
               if (got != exp_r) begin
                  if (got.cnt != exp_r.cnt)
                     $error("root_count exp %0d got %0d", exp_r.cnt, got.cnt);
                  if (got.r1 != exp_r.r1)
                     $error("first_real exp %h got %h", exp_r.r1, got.r1);
                  if (got.i1 != exp_r.i1)
                     $error("first_imag exp %h got %h", exp_r.i1, got.i1);
                  if (got.r2 != exp_r.r2)
                     $error("second_real exp %h got %h", exp_r.r2, got.r2);
                  if (got.i2 != exp_r.i2)
                     $error("second_imag exp %h got %h", exp_r.i2, got.i2);
                  if (got.sat != exp_r.sat)
                     $error("saturated exp %0d got %0d", exp_r.sat, got.sat);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: test/quadratic_root_solver_core_test.sv
// Testbench top for the quadratic root solver: stimulus, tolerance phases and verdict.
`timescale 1ns / 1ps
module quadratic_root_solver_core_test;
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic [qrs_pkg::REQ_W-1:0]   req_tdata = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [qrs_pkg::RSP_W-1:0]   rsp_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic                        csr_wr_en = 1'b0;
   logic [qrs_pkg::TOL_W-1:0]   csr_wr_data = '0;
   int                          fail_count;
   int                          pending;
   int                          cycle_count = 0;

   localparam int CYCLE_LIMIT = 400000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quadratic_root_solver_core dut (.*);

   quadratic_root_solver_core_checker checker_i (.*);

   // Hard stop if the pipeline hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL quadratic_root_solver_core");
         $finish;
      end
   end

   // Receiver: random stall before each transfer, sometimes none.
   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         repeat (gap) @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_tready <= 1'b0;
      end
   end

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8)) - 4);
         2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   // Send one coefficient set; gap drawn per transfer unless calm.
   task automatic send_coefs(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {c, b, a};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_then_set(input logic [qrs_pkg::TOL_W-1:0] tol);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tol;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [qrs_pkg::TOL_W-1:0] tols [5];
      logic calm;
      tols = '{16'd0, 16'd1, 16'd65535, 16'd300, 16'd7};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: linear cases, zero divisor, extremes, signs of D.
      send_coefs(0, 0, 0, 0);
      send_coefs(0, 0, 32'h10000, 0);
      send_coefs(0, 32'h20000, 32'h10000, 0);
      send_coefs(0, 1, 32'h7fffffff, 0);
      send_coefs(32'h10000, 32'hfffe0000, 32'h10000, 0);
      send_coefs(32'h10000, 0, 32'h10000, 0);
      send_coefs(32'h10000, 0, 32'hffff0000, 0);
      send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
      send_coefs(32'h80000000, 32'h80000000, 32'h80000000, 0);
      send_coefs(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
      send_coefs(1, 32'h80000000, 32'h80000000, 0);
      send_coefs(32'hffffffff, 32'h7fffffff, 1, 0);
      send_coefs(1, 0, 0, 0);
      send_coefs(32'hffffffff, 0, 32'hffffffff, 0);
      for (int p = 0; p < 5; p++) begin
         drain_then_set(tols[p]);
         if (p == 0) begin
            send_coefs(0, 0, 0, 0);
            send_coefs(0, 0, 5, 0);
            send_coefs(0, 3, 5, 0);
         end
         for (int k = 0; k < 220; k++) begin
            calm = (k % 60) < 12;
            send_coefs(pick_coef(), pick_coef(), pick_coef(), calm);
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS quadratic_root_solver_core");
      end else begin
         $display("FAIL quadratic_root_solver_core");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+design
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver_core.sv
test/quadratic_root_solver_core_checker.sv
test/quadratic_root_solver_core_test.sv
